[hw/rtl/smn_pkg.sv]
// shared types and constants for the softassign matrix normalizer
package smn_pkg;

  localparam int MAX_ROWS   = 64;
  localparam int MAX_COLS   = 64;
  localparam int VALUE_BITS = 32;
  localparam int FRAC_BITS  = VALUE_BITS - 8;
  localparam int ROW_W      = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int COL_W      = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int ENT_AW     = ROW_W + COL_W;
  localparam int SIZE_W     = 7;
  localparam int SUM_W      = VALUE_BITS + 8;
  localparam int DIVD_W     = VALUE_BITS + FRAC_BITS;
  localparam int DCNT_W     = $clog2(DIVD_W);
  localparam int PASS_W     = 5;
  localparam int MAX_PASSES = 16;
  localparam int RESET_PASSES = 10;
  localparam longint SUM_FLOOR = ((64'd1 << FRAC_BITS) + 64'd5000) / 64'd10000;

  typedef enum logic [2:0] {
    FN_WR_ENT  = 3'd0,
    FN_WR_ROW  = 3'd1,
    FN_WR_COL  = 3'd2,
    FN_RUN     = 3'd3,
    FN_RD_ENT  = 3'd4,
    FN_RD_ROW  = 3'd5,
    FN_RD_COL  = 3'd6,
    FN_NONE    = 3'd7
  } func_t;

  typedef enum logic [1:0] {
    REG_ROWS  = 2'd0,
    REG_COLS  = 2'd1,
    REG_PASS  = 2'd2,
    REG_MODE  = 2'd3
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_WAIT,
    ST_OUT_RD,
    ST_OUT_ACC,
    ST_SUM_RD,
    ST_SUM_ACC,
    ST_FLOOR,
    ST_SC_RD,
    ST_SC_DIV,
    ST_SC_WAIT,
    ST_OS_RD,
    ST_OS_DIV,
    ST_OS_WAIT
  } state_t;

endpackage

[hw/rtl/smn_divider.sv]
// bit-serial divider: floor(x * 2^FRAC_BITS / s), saturated to the value range
module smn_divider (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [smn_pkg::VALUE_BITS-1:0]   x,
  input  logic [smn_pkg::SUM_W-1:0]        s,
  output logic                             busy,
  output logic                             done,
  output logic [smn_pkg::VALUE_BITS-1:0]   q
);

  logic [smn_pkg::SUM_W-1:0]       rem;
  logic [smn_pkg::SUM_W-1:0]       divisor;
  logic [smn_pkg::DIVD_W-1:0]      dividend;
  logic [smn_pkg::VALUE_BITS-1:0]  quo;
  logic                            ovf;
  logic [smn_pkg::DCNT_W-1:0]      cnt;
  logic [smn_pkg::SUM_W:0]         trial;
  logic                            fits;

  assign trial = {rem, dividend[smn_pkg::DIVD_W-1]};
  assign fits  = (trial >= {1'b0, divisor});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        if (cnt == smn_pkg::DCNT_W'(smn_pkg::DIVD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      divisor  <= s;
      dividend <= {x, {smn_pkg::FRAC_BITS{1'b0}}};
      quo      <= '0;
      ovf      <= 1'b0;
    end else if (busy) begin
      // quotient bits shifted past the top mean saturation
      ovf      <= ovf | quo[smn_pkg::VALUE_BITS-1];
      quo      <= {quo[smn_pkg::VALUE_BITS-2:0], fits};
      rem      <= fits ? smn_pkg::SUM_W'(trial - {1'b0, divisor})
                       : trial[smn_pkg::SUM_W-1:0];
      dividend <= {dividend[smn_pkg::DIVD_W-2:0], 1'b0};
    end
  end

  assign q = ovf ? {smn_pkg::VALUE_BITS{1'b1}} : quo;

endmodule

[hw/rtl/softassign_matrix_normalizer.sv]
// top level: command decode, storage and the normalization sequencer
// loads write the store when accepted; reads go through a registered memory read then an output register
// a run walks every row line then every column line in each pass (mixture mode: one pass over column lines)
// per line: one outlier read, a sum of the outlier and its elements, then each element divided by the
// floored sum through the shared divider, then the outlier (left alone in mixture mode)
// synchronous reset clears the sequencer state, out_valid and the config registers; memories are not cleared
module softassign_matrix_normalizer (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [2:0]                      func,
  input  logic [5:0]                      row_index,
  input  logic [5:0]                      col_index,
  input  logic [31:0]                     write_value,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [31:0]                     read_value,
  output logic                            run_done,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [1:0]                      cfg_index,
  input  logic [6:0]                      cfg_data
);

  localparam int VB = smn_pkg::VALUE_BITS;

  logic [smn_pkg::SIZE_W-1:0] rows_in_use, cols_in_use;
  logic [smn_pkg::PASS_W-1:0] pass_count;
  logic                       norm_mode;

  smn_pkg::state_t state, state_next;
  logic [smn_pkg::ROW_W-1:0]  line, line_next;
  logic [smn_pkg::COL_W-1:0]  elem, elem_next;
  logic                       orient, orient_next;   // 0 row line, 1 column line
  logic [smn_pkg::PASS_W-1:0] pass, pass_next;
  logic [smn_pkg::SUM_W-1:0]  acc, acc_next;
  smn_pkg::func_t             rd_func, rd_func_next;
  logic                       out_valid_next, run_done_next;
  logic [31:0]                read_value_next;

  logic [VB-1:0] ent_mem [smn_pkg::MAX_ROWS*smn_pkg::MAX_COLS];
  logic [VB-1:0] row_mem [smn_pkg::MAX_ROWS];
  logic [VB-1:0] col_mem [smn_pkg::MAX_COLS];
  logic [VB-1:0] ent_rdata, row_rdata, col_rdata, ol_rdata;
  logic [smn_pkg::ENT_AW-1:0] ent_addr;
  logic [smn_pkg::ROW_W-1:0]  row_addr;
  logic [smn_pkg::COL_W-1:0]  col_addr;
  logic                       ent_we, row_we, col_we;
  logic [VB-1:0]              wdata;

  logic [smn_pkg::SIZE_W-1:0] nr, nc, lines, elems;
  logic [smn_pkg::PASS_W-1:0] np;
  logic [smn_pkg::ROW_W-1:0]  ri_c;
  logic [smn_pkg::COL_W-1:0]  ci_c;
  logic                       in_fire, out_fire;
  smn_pkg::func_t             fn;

  logic                       div_start, div_busy, div_done;
  logic [VB-1:0]              div_x, div_q;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_use <= smn_pkg::SIZE_W'(smn_pkg::MAX_ROWS);
      cols_in_use <= smn_pkg::SIZE_W'(smn_pkg::MAX_COLS);
      pass_count  <= smn_pkg::PASS_W'(smn_pkg::RESET_PASSES);
      norm_mode   <= 1'b0;
    end else if (cfg_valid) begin
      case (smn_pkg::reg_idx_t'(cfg_index))
        smn_pkg::REG_ROWS: rows_in_use <= cfg_data;
        smn_pkg::REG_COLS: cols_in_use <= cfg_data;
        smn_pkg::REG_PASS: pass_count  <= cfg_data[smn_pkg::PASS_W-1:0];
        smn_pkg::REG_MODE: norm_mode   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // size, pass count and index clamping, and line lengths for the current orientation
  always_comb begin
    nr = (rows_in_use == '0) ? smn_pkg::SIZE_W'(1)
       : (rows_in_use > smn_pkg::SIZE_W'(smn_pkg::MAX_ROWS)) ? smn_pkg::SIZE_W'(smn_pkg::MAX_ROWS)
       : rows_in_use;
    nc = (cols_in_use == '0) ? smn_pkg::SIZE_W'(1)
       : (cols_in_use > smn_pkg::SIZE_W'(smn_pkg::MAX_COLS)) ? smn_pkg::SIZE_W'(smn_pkg::MAX_COLS)
       : cols_in_use;
    np = (pass_count == '0) ? smn_pkg::PASS_W'(1)
       : (pass_count > smn_pkg::PASS_W'(smn_pkg::MAX_PASSES)) ? smn_pkg::PASS_W'(smn_pkg::MAX_PASSES)
       : pass_count;
    ri_c = (smn_pkg::SIZE_W'(row_index) > nr - 1'b1) ? smn_pkg::ROW_W'(nr - 1'b1) : row_index;
    ci_c = (smn_pkg::SIZE_W'(col_index) > nc - 1'b1) ? smn_pkg::COL_W'(nc - 1'b1) : col_index;
    lines = orient ? nc : nr;
    elems = orient ? nr : nc;
  end

  assign fn       = smn_pkg::func_t'(func);
  assign in_stall = (state != smn_pkg::ST_IDLE) || (out_valid && out_stall);
  assign in_fire  = in_valid && !in_stall;
  assign out_fire = out_valid && !out_stall;

  always_comb begin
    if (state == smn_pkg::ST_IDLE) begin
      ent_addr = {ri_c, ci_c};
      row_addr = ri_c;
      col_addr = ci_c;
    end else begin
      ent_addr = orient ? {elem, line} : {line, elem};
      row_addr = line;
      col_addr = line;
    end
  end

  assign ol_rdata = orient ? col_rdata : row_rdata;

  always_ff @(posedge clk) begin
    if (ent_we) ent_mem[ent_addr] <= wdata;
    ent_rdata <= ent_mem[ent_addr];
  end

  always_ff @(posedge clk) begin
    if (row_we) row_mem[row_addr] <= wdata;
    row_rdata <= row_mem[row_addr];
  end

  always_ff @(posedge clk) begin
    if (col_we) col_mem[col_addr] <= wdata;
    col_rdata <= col_mem[col_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= smn_pkg::ST_IDLE;
      out_valid <= 1'b0;
      line      <= '0;
      elem      <= '0;
      orient    <= 1'b0;
      pass      <= '0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
      line      <= line_next;
      elem      <= elem_next;
      orient    <= orient_next;
      pass      <= pass_next;
    end
  end

  always_ff @(posedge clk) begin
    acc        <= acc_next;
    rd_func    <= rd_func_next;
    read_value <= read_value_next;
    run_done   <= run_done_next;
  end

  always_comb begin
    state_next      = state;
    line_next       = line;
    elem_next       = elem;
    orient_next     = orient;
    pass_next       = pass;
    acc_next        = acc;
    rd_func_next    = rd_func;
    out_valid_next  = out_valid && !out_fire;
    read_value_next = read_value;
    run_done_next   = run_done;
    ent_we          = 1'b0;
    row_we          = 1'b0;
    col_we          = 1'b0;
    wdata           = div_q;
    div_start       = 1'b0;
    div_x           = ent_rdata;

    case (state)
      smn_pkg::ST_IDLE: begin
        if (in_fire) begin
          wdata        = write_value;
          rd_func_next = fn;
          case (fn)
            smn_pkg::FN_WR_ENT: ent_we = 1'b1;
            smn_pkg::FN_WR_ROW: row_we = 1'b1;
            smn_pkg::FN_WR_COL: col_we = 1'b1;
            smn_pkg::FN_RUN: begin
              line_next   = '0;
              pass_next   = '0;
              orient_next = norm_mode;
              state_next  = smn_pkg::ST_OUT_RD;
            end
            smn_pkg::FN_RD_ENT, smn_pkg::FN_RD_ROW, smn_pkg::FN_RD_COL:
              state_next = smn_pkg::ST_RD_WAIT;
            default: ;
          endcase
        end
      end
      smn_pkg::ST_RD_WAIT: begin
        case (rd_func)
          smn_pkg::FN_RD_ROW: read_value_next = row_rdata;
          smn_pkg::FN_RD_COL: read_value_next = col_rdata;
          default:            read_value_next = ent_rdata;
        endcase
        run_done_next  = 1'b0;
        out_valid_next = 1'b1;
        state_next     = smn_pkg::ST_IDLE;
      end
      smn_pkg::ST_OUT_RD: state_next = smn_pkg::ST_OUT_ACC;
      smn_pkg::ST_OUT_ACC: begin
        acc_next   = smn_pkg::SUM_W'(ol_rdata);
        elem_next  = '0;
        state_next = smn_pkg::ST_SUM_RD;
      end
      smn_pkg::ST_SUM_RD: state_next = smn_pkg::ST_SUM_ACC;
      smn_pkg::ST_SUM_ACC: begin
        acc_next = acc + smn_pkg::SUM_W'(ent_rdata);
        if (elem == smn_pkg::COL_W'(elems - 1'b1)) begin
          state_next = smn_pkg::ST_FLOOR;
        end else begin
          elem_next  = elem + 1'b1;
          state_next = smn_pkg::ST_SUM_RD;
        end
      end
      smn_pkg::ST_FLOOR: begin
        if (acc < smn_pkg::SUM_W'(smn_pkg::SUM_FLOOR)) acc_next = smn_pkg::SUM_W'(smn_pkg::SUM_FLOOR);
        elem_next  = '0;
        state_next = smn_pkg::ST_SC_RD;
      end
      smn_pkg::ST_SC_RD: state_next = smn_pkg::ST_SC_DIV;
      smn_pkg::ST_SC_DIV: begin
        div_start  = 1'b1;
        state_next = smn_pkg::ST_SC_WAIT;
      end
      smn_pkg::ST_SC_WAIT: begin
        if (div_done) begin
          ent_we = 1'b1;
          if (elem != smn_pkg::COL_W'(elems - 1'b1)) begin
            elem_next  = elem + 1'b1;
            state_next = smn_pkg::ST_SC_RD;
          end else if (!orient || !norm_mode) begin
            state_next = smn_pkg::ST_OS_RD;
          end else begin
            // mixture mode leaves the column outliers alone
            read_value_next = '0;
            run_done_next   = 1'b1;
            out_valid_next  = 1'b1;
            line_next       = line + 1'b1;
            state_next      = smn_pkg::ST_OUT_RD;
            if (line == smn_pkg::ROW_W'(lines - 1'b1)) state_next = smn_pkg::ST_IDLE;
            else out_valid_next = out_valid && !out_fire;
          end
        end
      end
      smn_pkg::ST_OS_RD: state_next = smn_pkg::ST_OS_DIV;
      smn_pkg::ST_OS_DIV: begin
        div_x      = ol_rdata;
        div_start  = 1'b1;
        state_next = smn_pkg::ST_OS_WAIT;
      end
      smn_pkg::ST_OS_WAIT: begin
        if (div_done) begin
          row_we     = !orient;
          col_we     = orient;
          state_next = smn_pkg::ST_OUT_RD;
          if (line != smn_pkg::ROW_W'(lines - 1'b1)) begin
            line_next = line + 1'b1;
          end else begin
            line_next = '0;
            if (!orient) begin
              orient_next = 1'b1;
            end else if (pass == np - 1'b1) begin
              read_value_next = '0;
              run_done_next   = 1'b1;
              out_valid_next  = 1'b1;
              state_next      = smn_pkg::ST_IDLE;
            end else begin
              pass_next   = pass + 1'b1;
              orient_next = 1'b0;
            end
          end
        end
      end
      default: state_next = smn_pkg::ST_IDLE;
    endcase
  end

  smn_divider u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .x     (div_x),
    .s     (acc),
    .busy  (div_busy),
    .done  (div_done),
    .q     (div_q)
  );

  a_div_idle: assert property (@(posedge clk) disable iff (rst) div_start |-> !div_busy)
    else $error("divider started while busy");
  a_sum_floor: assert property (@(posedge clk) disable iff (rst)
    (state == smn_pkg::ST_SC_DIV || state == smn_pkg::ST_OS_DIV)
      |-> acc >= smn_pkg::SUM_W'(smn_pkg::SUM_FLOOR))
    else $error("divisor below floor");
  a_out_free: assert property (@(posedge clk) disable iff (rst)
    (state == smn_pkg::ST_RD_WAIT) |-> !out_valid)
    else $error("read result would overwrite pending output");
  a_wait_div: assert property (@(posedge clk) disable iff (rst)
    (state == smn_pkg::ST_SC_WAIT && !div_done) |-> div_busy)
    else $error("waiting on an idle divider");

endmodule

[sim/softassign_matrix_normalizer_test.sv]
// testbench for the softassign matrix normalizer: directed and random commands
`timescale 1ns / 1ps

module softassign_matrix_normalizer_test;

  localparam longint unsigned VMAX = 64'hFFFF_FFFF;

  typedef struct packed {
    logic [31:0] value;
    logic        done;
  } answer_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  func = 3'd0;
  logic [5:0]  row_index = 6'd0;
  logic [5:0]  col_index = 6'd0;
  logic [31:0] write_value = 32'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] read_value;
  logic        run_done;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = 2'd0;
  logic [6:0]  cfg_data = 7'd0;

  softassign_matrix_normalizer i_dut (
    .clk, .rst, .in_valid, .in_stall, .func, .row_index, .col_index, .write_value,
    .out_valid, .out_stall, .read_value, .run_done,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  // predictor state
  longint unsigned ent_mem [smn_pkg::MAX_ROWS*smn_pkg::MAX_COLS];
  longint unsigned row_out [smn_pkg::MAX_ROWS];
  longint unsigned col_out [smn_pkg::MAX_COLS];
  bit              ent_set [smn_pkg::MAX_ROWS*smn_pkg::MAX_COLS];
  bit              row_set [smn_pkg::MAX_ROWS];
  bit              col_set [smn_pkg::MAX_COLS];
  int unsigned     rows_reg = 64, cols_reg = 64, pass_reg = 10, mode_reg = 0;

  answer_t answer_q [$];
  int      errors = 0;
  bit      quiet = 1'b0;
  int      hold_req = 0;

  initial forever #4 clk = ~clk;

  initial begin
    #5s;
    $display("Mismatches found");
    $finish;
  end

  function automatic int eff_size(int unsigned v, int maxv);
    if (v < 1) return 1;
    if (v > maxv) return maxv;
    return int'(v);
  endfunction

  function automatic longint unsigned scaled(longint unsigned x, longint unsigned s);
    longint unsigned q;
    q = (x << smn_pkg::FRAC_BITS) / s;
    return (q > VMAX) ? VMAX : q;
  endfunction

  function automatic longint unsigned floored(longint unsigned s);
    return (s < smn_pkg::SUM_FLOOR) ? smn_pkg::SUM_FLOOR : s;
  endfunction

  task automatic column_norm(int nr, int nc, bit with_outliers);
    longint unsigned csum [smn_pkg::MAX_COLS];
    for (int c = 0; c < nc; c++) begin
      csum[c] = col_out[c];
      for (int r = 0; r < nr; r++) csum[c] += ent_mem[r*smn_pkg::MAX_COLS+c];
      csum[c] = floored(csum[c]);
      if (with_outliers) col_out[c] = scaled(col_out[c], csum[c]);
    end
    for (int r = 0; r < nr; r++)
      for (int c = 0; c < nc; c++)
        ent_mem[r*smn_pkg::MAX_COLS+c] = scaled(ent_mem[r*smn_pkg::MAX_COLS+c], csum[c]);
  endtask

  task automatic normalize_model();
    int nr, nc, np;
    longint unsigned rsum;
    nr = eff_size(rows_reg, smn_pkg::MAX_ROWS);
    nc = eff_size(cols_reg, smn_pkg::MAX_COLS);
    np = eff_size(pass_reg, smn_pkg::MAX_PASSES);
    if (mode_reg != 0) begin
      column_norm(nr, nc, 1'b0);
    end else begin
      for (int p = 0; p < np; p++) begin
        for (int r = 0; r < nr; r++) begin
          rsum = row_out[r];
          for (int c = 0; c < nc; c++) rsum += ent_mem[r*smn_pkg::MAX_COLS+c];
          rsum = floored(rsum);
          for (int c = 0; c < nc; c++)
            ent_mem[r*smn_pkg::MAX_COLS+c] = scaled(ent_mem[r*smn_pkg::MAX_COLS+c], rsum);
          row_out[r] = scaled(row_out[r], rsum);
        end
        column_norm(nr, nc, 1'b1);
      end
    end
  endtask

  task automatic predict(smn_pkg::func_t f, int r, int c, logic [31:0] v);
    int ri, ci;
    answer_t a;
    ri = r;
    ci = c;
    if (ri > eff_size(rows_reg, smn_pkg::MAX_ROWS) - 1)
      ri = eff_size(rows_reg, smn_pkg::MAX_ROWS) - 1;
    if (ci > eff_size(cols_reg, smn_pkg::MAX_COLS) - 1)
      ci = eff_size(cols_reg, smn_pkg::MAX_COLS) - 1;
    a = '0;
    case (f)
      smn_pkg::FN_WR_ENT: begin
        ent_mem[ri*smn_pkg::MAX_COLS+ci] = 64'(v);
        ent_set[ri*smn_pkg::MAX_COLS+ci] = 1'b1;
      end
      smn_pkg::FN_WR_ROW: begin
        row_out[ri] = 64'(v);
        row_set[ri] = 1'b1;
      end
      smn_pkg::FN_WR_COL: begin
        col_out[ci] = 64'(v);
        col_set[ci] = 1'b1;
      end
      smn_pkg::FN_RUN: begin
        normalize_model();
        a.done = 1'b1;
        answer_q.push_back(a);
      end
      smn_pkg::FN_RD_ENT: begin
        a.value = 32'(ent_mem[ri*smn_pkg::MAX_COLS+ci]);
        answer_q.push_back(a);
      end
      smn_pkg::FN_RD_ROW: begin
        a.value = 32'(row_out[ri]);
        answer_q.push_back(a);
      end
      smn_pkg::FN_RD_COL: begin
        a.value = 32'(col_out[ci]);
        answer_q.push_back(a);
      end
      default: ;
    endcase
  endtask

  // entered and left at a falling edge; valid stays high when items follow back to back
  task automatic send_cmd(smn_pkg::func_t f, int r, int c, logic [31:0] v);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    func <= f;
    row_index <= r[5:0];
    col_index <= c[5:0];
    write_value <= v;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    predict(f, r, c, v);
    @(negedge clk);
  endtask

  // sender pauses until every answer is back, then lets the block finish writes
  task automatic drain();
    in_valid <= 1'b0;
    wait (answer_q.size() == 0);
    repeat (12) @(negedge clk);
  endtask

  task automatic cfg_write(smn_pkg::reg_idx_t idx, logic [6:0] d);
    drain();
    cfg_index <= idx;
    cfg_data <= d;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      smn_pkg::REG_ROWS: rows_reg = d;
      smn_pkg::REG_COLS: cols_reg = d;
      smn_pkg::REG_PASS: pass_reg = d;
      default:           mode_reg = d[0];
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 4))
      0: return $urandom();
      1: return $urandom_range(0, 32'h0200_0000);
      2: return $urandom_range(0, 3000);
      3: return ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'd0;
      default: return $urandom_range(32'h0010_0000, 32'h0100_0000);
    endcase
  endfunction

  // every store cell the block can touch with the current sizes gets a value
  task automatic fill_region();
    int nr, nc;
    nr = eff_size(rows_reg, smn_pkg::MAX_ROWS);
    nc = eff_size(cols_reg, smn_pkg::MAX_COLS);
    for (int r = 0; r < nr; r++) begin
      if (!row_set[r]) send_cmd(smn_pkg::FN_WR_ROW, r, 0, rand_value());
      for (int c = 0; c < nc; c++)
        if (!ent_set[r*smn_pkg::MAX_COLS+c]) send_cmd(smn_pkg::FN_WR_ENT, r, c, rand_value());
    end
    for (int c = 0; c < nc; c++)
      if (!col_set[c]) send_cmd(smn_pkg::FN_WR_COL, 0, c, rand_value());
  endtask

  task automatic set_sizes(logic [6:0] nr, logic [6:0] nc, logic [6:0] np, logic md);
    cfg_write(smn_pkg::REG_ROWS, nr);
    cfg_write(smn_pkg::REG_COLS, nc);
    cfg_write(smn_pkg::REG_PASS, np);
    cfg_write(smn_pkg::REG_MODE, {6'd0, md});
    fill_region();
  endtask

  task automatic test_load_read();
    set_sizes(7'd2, 7'd3, 7'd1, 1'b0);
    send_cmd(smn_pkg::FN_WR_ENT, 0, 0, 32'hFFFF_FFFF);
    send_cmd(smn_pkg::FN_WR_ENT, 1, 2, 32'd0);
    send_cmd(smn_pkg::FN_WR_ROW, 1, 0, 32'hA5A5_5A5A);
    send_cmd(smn_pkg::FN_WR_COL, 0, 2, 32'h0100_0000);
    send_cmd(smn_pkg::FN_RD_ENT, 0, 0, 32'd0);
    send_cmd(smn_pkg::FN_RD_ENT, 63, 63, 32'd0);      // clamped to last row and column
    send_cmd(smn_pkg::FN_RD_ROW, 63, 0, 32'd0);
    send_cmd(smn_pkg::FN_RD_COL, 0, 63, 32'd0);
    send_cmd(smn_pkg::FN_NONE, 5, 5, 32'hFFFF_FFFF);  // unused code, no answer
    send_cmd(smn_pkg::FN_WR_ENT, 63, 0, 32'h0000_0001);
    send_cmd(smn_pkg::FN_RD_ENT, 1, 0, 32'd0);
  endtask

  task automatic test_rpm_run();
    set_sizes(7'd2, 7'd2, 7'd2, 1'b0);
    send_cmd(smn_pkg::FN_WR_ENT, 0, 0, 32'd100);      // tiny sums hit the floor
    send_cmd(smn_pkg::FN_WR_ENT, 0, 1, 32'd0);
    send_cmd(smn_pkg::FN_WR_ROW, 0, 0, 32'd5);
    send_cmd(smn_pkg::FN_RUN, 0, 0, 32'd0);
    send_cmd(smn_pkg::FN_RD_ENT, 0, 0, 32'd0);
    send_cmd(smn_pkg::FN_RD_ROW, 0, 0, 32'd0);
    send_cmd(smn_pkg::FN_RD_COL, 0, 1, 32'd0);
    set_sizes(7'd2, 7'd2, 7'd0, 1'b0);       // pass count zero acts as one
    send_cmd(smn_pkg::FN_RUN, 0, 0, 32'd0);
    set_sizes(7'd2, 7'd2, 7'd31, 1'b0);      // above the maximum
    send_cmd(smn_pkg::FN_RUN, 0, 0, 32'd0);
    send_cmd(smn_pkg::FN_RD_ENT, 1, 1, 32'd0);
    set_sizes(7'd2, 7'd2, 7'd16, 1'b0);
    send_cmd(smn_pkg::FN_RUN, 0, 0, 32'd0);
  endtask

  task automatic test_sizes_extreme();
    set_sizes(7'd127, 7'd0, 7'd1, 1'b0);     // acts as 64 rows by one column
    send_cmd(smn_pkg::FN_RUN, 0, 0, 32'd0);
    send_cmd(smn_pkg::FN_RD_ENT, 63, 9, 32'd0);
    set_sizes(7'd0, 7'd127, 7'd1, 1'b1);     // one row by 64 columns, mixture pass
    send_cmd(smn_pkg::FN_RUN, 0, 0, 32'd0);
    send_cmd(smn_pkg::FN_RD_ENT, 37, 50, 32'd0);
    send_cmd(smn_pkg::FN_RD_COL, 0, 63, 32'd0);
    set_sizes(7'd0, 7'd127, 7'd3, 1'b0);
    send_cmd(smn_pkg::FN_RUN, 0, 0, 32'd0);
    send_cmd(smn_pkg::FN_RD_COL, 0, 63, 32'd0);
  endtask

  task automatic test_backpressure();
    set_sizes(7'd4, 7'd4, 7'd1, 1'b0);
    quiet = 1'b1;
    hold_req = 200;
    for (int k = 0; k < 24; k++)
      send_cmd(smn_pkg::func_t'(smn_pkg::FN_RD_ENT + (k % 3)), $urandom_range(0, 63),
               $urandom_range(0, 63), 0);
    quiet = 1'b0;
    drain();
  endtask

  task automatic test_random();
    logic [6:0] nr, nc;
    int pick;
    for (int ph = 0; ph < 6; ph++) begin
      nr = ($urandom_range(0, 7) == 0) ? 7'($urandom_range(0, 127)) : 7'($urandom_range(0, 5));
      nc = 7'($urandom_range(0, 5));
      if (nr > 8) nc = 7'($urandom_range(0, 2));
      set_sizes(nr, nc, 7'($urandom_range(0, 31)), 1'($urandom_range(0, 1)));
      quiet = (ph == 2);
      for (int k = 0; k < 30; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 4) send_cmd(smn_pkg::FN_RUN, 0, 0, $urandom());
        else if (pick < 6) send_cmd(smn_pkg::FN_NONE, $urandom_range(0, 63), 0, $urandom());
        else if (pick < 40)
          send_cmd(smn_pkg::func_t'($urandom_range(0, 2)), $urandom_range(0, 63),
                   $urandom_range(0, 63), rand_value());
        else
          send_cmd(smn_pkg::func_t'($urandom_range(4, 6)), $urandom_range(0, 63),
                   $urandom_range(0, 63), $urandom());
      end
      quiet = 1'b0;
    end
  endtask

  // receiver: random stall before each transfer, plus an occasional long hold
  initial begin
    int n;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      n = hold_req + (quiet ? 0 : $urandom_range(0, 5));
      hold_req = 0;
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    answer_t a;
    if (!rst && out_valid && !out_stall) begin
      if (answer_q.size() == 0) begin
        $error("unexpected transfer: read_value %h run_done %b", read_value, run_done);
        errors++;
      end else begin
        a = answer_q.pop_front();
        if (read_value !== a.value) begin
          $error("read_value expected %h actual %h", a.value, read_value);
          errors++;
        end
        if (run_done !== a.done) begin
          $error("run_done expected %b actual %b", a.done, run_done);
          errors++;
        end
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_load_read();
    test_rpm_run();
    test_sizes_extreme();
    test_backpressure();
    test_random();
    drain();
    repeat (20) @(negedge clk);
    if (errors == 0 && answer_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
